// ===== hw/rtl/ebrp_pkg.sv =====
// ----------------------------------------------------------------------------
// ebrp_pkg: shared definitions for the edge balanced range partitioner
// Widths of node ids and counters, the result word and the push bundle that
// carries up to three results from the core into the result queue.
// ----------------------------------------------------------------------------
package ebrp_pkg;

  // Node id and edge counter widths.
  localparam int NODE_ID_BITS = 32;
  localparam int COUNT_BITS   = 32;
  // The threshold carries one bit more than the counters and saturates.
  localparam int THR_BITS     = COUNT_BITS + 1;

  // One input word causes at most this many results.
  localparam int MAX_RESULTS  = 3;
  // Result queue depth and the width of its fill count.
  localparam int QUEUE_DEPTH  = 4;
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_BITS    = $clog2(QUEUE_DEPTH);
  localparam int PCNT_BITS    = $clog2(MAX_RESULTS + 1);

  // One result word.
  typedef struct packed {
    logic [NODE_ID_BITS-1:0] first_node;
    logic [COUNT_BITS-1:0]   node_total;
    logic [COUNT_BITS-1:0]   edge_total;
    logic                    is_end_bound;
    logic                    last_result;
  } result_t;

  // Results produced by one processed input word, in order from entry 0.
  typedef struct packed {
    logic [PCNT_BITS-1:0]              count;
    result_t [MAX_RESULTS-1:0]         res;
  } push_t;

endpackage

// ===== hw/rtl/ebrp_ifs.sv =====
// ----------------------------------------------------------------------------
// ebrp_ifs: stream channels of the edge balanced range partitioner
// Input channel with one edge per word and result channel with one
// partition record per word, both valid/ready.
// ----------------------------------------------------------------------------
interface ebrp_in_if;
  logic                              valid;
  logic                              ready;
  logic [ebrp_pkg::NODE_ID_BITS-1:0] target_node;
  logic                              last_edge;

  modport source (output valid, output target_node, output last_edge, input ready);
  modport sink   (input valid, input target_node, input last_edge, output ready);
endinterface

interface ebrp_out_if;
  logic                              valid;
  logic                              ready;
  logic [ebrp_pkg::NODE_ID_BITS-1:0] first_node;
  logic [ebrp_pkg::COUNT_BITS-1:0]   node_total;
  logic [ebrp_pkg::COUNT_BITS-1:0]   edge_total;
  logic                              is_end_bound;
  logic                              last_result;

  modport source (output valid, output first_node, output node_total, output edge_total,
                  output is_end_bound, output last_result, input ready);
  modport sink   (input valid, input first_node, input node_total, input edge_total,
                  input is_end_bound, input last_result, output ready);
endinterface

// ===== hw/rtl/ebrp_core.sv =====
// ----------------------------------------------------------------------------
// ebrp_core: input register, running partition state and cut decision
// Holds one edge word in an input register, decides in one pass whether the
// open partition closes, and hands all results of that word to the queue.
// ----------------------------------------------------------------------------
module ebrp_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input word.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ebrp_pkg::NODE_ID_BITS-1:0] in_node,
  input  logic                            in_last,
  // Quota register write.
  input  logic                            cfg_we,
  input  logic [ebrp_pkg::COUNT_BITS-1:0] cfg_wdata,
  // Result queue side.
  input  logic                            room,
  output ebrp_pkg::push_t                 push
);
  import ebrp_pkg::*;

  // Input register.
  logic                    vld_r;
  logic [NODE_ID_BITS-1:0] node_r;
  logic                    last_r;

  // Running state.
  logic [COUNT_BITS-1:0]   epp_r;
  logic [COUNT_BITS-1:0]   seen_r, seen_nxt;
  logic [COUNT_BITS-1:0]   ebn_r, ebn_nxt;
  logic [NODE_ID_BITS-1:0] open_r, open_nxt;
  logic                    ov_r, ov_nxt;
  logic [THR_BITS-1:0]     thr_r, thr_nxt;
  logic [NODE_ID_BITS-1:0] pf_r, pf_nxt;
  logic [COUNT_BITS-1:0]   pn_r, pn_nxt;
  logic [COUNT_BITS-1:0]   pe_r, pe_nxt;

  logic process;
  logic new_node, cut, move;
  logic [COUNT_BITS-1:0]   tail;
  logic [THR_BITS:0]       twice_thr, mid_sum, thr_sum;
  logic [THR_BITS-1:0]     thr_step;
  logic [NODE_ID_BITS-1:0] pf0, pf1;
  logic [COUNT_BITS-1:0]   pn0, pn1, pn2, pe0, pe1, pe2;
  result_t                 cut_res, part_res, mark_res;

  assign process  = vld_r && room;
  assign in_ready = !vld_r || room;

  // Cut decision and next partition state for the registered word.
  always_comb begin
    new_node  = !ov_r || (open_r != node_r);
    cut       = ov_r && new_node && ({1'b0, seen_r} >= thr_r);
    tail      = seen_r - ebn_r;
    // The previous node moves on when twice the threshold is below the sum
    // of its first and one-past-last edge counts.
    twice_thr = {thr_r, 1'b0};
    mid_sum   = {2'b00, ebn_r} + {2'b00, seen_r};
    move      = twice_thr < mid_sum;
    // Threshold step saturates at the all-ones value.
    thr_sum   = {1'b0, thr_r} + {2'b00, epp_r};
    thr_step  = thr_sum[THR_BITS] ? {THR_BITS{1'b1}} : thr_sum[THR_BITS-1:0];

    pf0 = ov_r ? pf_r : node_r;
    pn0 = ov_r ? pn_r : '0;
    pe0 = ov_r ? pe_r : '0;

    cut_res.first_node   = pf0;
    cut_res.node_total   = move ? pn0 - COUNT_BITS'(1) : pn0;
    cut_res.edge_total   = move ? pe0 - tail : pe0;
    cut_res.is_end_bound = 1'b0;
    cut_res.last_result  = !last_r;

    pf1     = pf0;
    pn1     = pn0;
    pe1     = pe0;
    thr_nxt = thr_r;
    if (cut) begin
      pf1     = move ? open_r : node_r;
      pn1     = move ? COUNT_BITS'(1) : '0;
      pe1     = move ? tail : '0;
      thr_nxt = thr_step;
    end

    pn2      = new_node ? pn1 + COUNT_BITS'(1) : pn1;
    ebn_nxt  = new_node ? seen_r : ebn_r;
    open_nxt = node_r;
    ov_nxt   = 1'b1;
    pe2      = pe1 + COUNT_BITS'(1);
    seen_nxt = seen_r + COUNT_BITS'(1);
    pf_nxt   = pf1;
    pn_nxt   = pn2;
    pe_nxt   = pe2;

    part_res.first_node   = pf1;
    part_res.node_total   = pn2;
    part_res.edge_total   = pe2;
    part_res.is_end_bound = 1'b0;
    part_res.last_result  = 1'b0;

    mark_res.first_node   = node_r + NODE_ID_BITS'(1);
    mark_res.node_total   = '0;
    mark_res.edge_total   = '0;
    mark_res.is_end_bound = 1'b1;
    mark_res.last_result  = 1'b1;

    // The stream end clears the running state; the threshold takes the quota.
    if (last_r) begin
      seen_nxt = '0;
      ebn_nxt  = '0;
      open_nxt = '0;
      ov_nxt   = 1'b0;
      thr_nxt  = {1'b0, epp_r};
      pf_nxt   = '0;
      pn_nxt   = '0;
      pe_nxt   = '0;
    end

    // Pack the results in order: closed partition, open partition, marker.
    push.count  = '0;
    push.res[0] = cut ? cut_res : part_res;
    push.res[1] = cut ? part_res : mark_res;
    push.res[2] = mark_res;
    if (process) begin
      push.count = PCNT_BITS'({1'b0, cut} + {last_r, 1'b0});
    end
  end

  // Input register load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      node_r <= in_node;
      last_r <= in_last;
    end
  end

  // Running state update and quota register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epp_r  <= COUNT_BITS'(1);
      seen_r <= '0;
      ebn_r  <= '0;
      open_r <= '0;
      ov_r   <= 1'b0;
      thr_r  <= THR_BITS'(1);
      pf_r   <= '0;
      pn_r   <= '0;
      pe_r   <= '0;
    end else begin
      if (process) begin
        seen_r <= seen_nxt;
        ebn_r  <= ebn_nxt;
        open_r <= open_nxt;
        ov_r   <= ov_nxt;
        thr_r  <= thr_nxt;
        pf_r   <= pf_nxt;
        pn_r   <= pn_nxt;
        pe_r   <= pe_nxt;
      end
      // The threshold follows the quota only before the first edge.
      if (cfg_we) begin
        epp_r <= cfg_wdata;
        if (!ov_r && seen_r == '0) begin
          thr_r <= {1'b0, cfg_wdata};
        end
      end
    end
  end

endmodule

// ===== hw/rtl/ebrp_result_queue.sv =====
// ----------------------------------------------------------------------------
// ebrp_result_queue: shifting result queue
// Four result entries that drain from entry zero; up to three words are
// appended together behind what stays after the current pop.
// ----------------------------------------------------------------------------
module ebrp_result_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ebrp_pkg::push_t       push,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ebrp_pkg::result_t     out_word
);
  import ebrp_pkg::*;

  result_t                q_r   [QUEUE_DEPTH];
  result_t                q_nxt [QUEUE_DEPTH];
  logic [QCNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [QCNT_BITS-1:0]   base;
  logic [QCNT_BITS-1:0]   slot;
  logic                   pop;

  assign out_valid = cnt_r != '0;
  assign out_word  = q_r[0];
  assign pop       = out_valid && out_ready;
  assign base      = cnt_r - QCNT_BITS'(pop);
  // Room for a full set of results after this cycle's pop.
  assign room      = base <= QCNT_BITS'(QUEUE_DEPTH - MAX_RESULTS);
  assign cnt_nxt   = base + QCNT_BITS'(push.count);

  // Shift on pop, then append the pushed words.
  always_comb begin
    slot = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && i < QUEUE_DEPTH - 1) begin
        q_nxt[i] = q_r[QIDX_BITS'(i + 1)];
      end else begin
        q_nxt[i] = q_r[i];
      end
      slot = QCNT_BITS'(i) - base;
      if (QCNT_BITS'(i) >= base && slot < QCNT_BITS'(push.count)) begin
        q_nxt[i] = push.res[slot[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

// ===== hw/rtl/edge_balanced_range_partitioner_top.sv =====
// ----------------------------------------------------------------------------
// edge_balanced_range_partitioner_top: edge balanced range partitioner
// Cuts a sorted stream of edge target nodes into contiguous node ranges of
// about one quota of edges each; emits a record per range and an end marker.
// ----------------------------------------------------------------------------
// The block accepts one edge word per clock cycle unless held by the result
// queue. Each word passes through an input register and one pass of compare
// and add logic against the running counters, and its results (none, a closed
// partition, and on the final edge the open partition and the end marker)
// enter a four-entry result queue that drains one record per cycle while the
// output is ready. Input is taken while the input register is empty or the
// queue, after the current pop, holds at most one record; with the output
// always ready, a stream that produces at most one record per edge keeps the
// full rate, and an edge that yields several records can hold the next edge.
// The quota register is to be written by the user through cfg_we and cfg_wdata
// only while the block is idle; the block itself does not enforce this. Before
// the first edge of a stream a quota write also reloads the cut threshold.
module edge_balanced_range_partitioner_top (
  input  logic                            clk,
  input  logic                            rst_n,
  ebrp_in_if.sink                         in_ch,
  ebrp_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ebrp_pkg::COUNT_BITS-1:0] cfg_wdata
);
  import ebrp_pkg::*;

  push_t   push;
  logic    room;
  result_t out_word;

  // Input register, state and cut logic.
  ebrp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_node   (in_ch.target_node),
    .in_last   (in_ch.last_edge),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .room      (room),
    .push      (push)
  );

  // Result queue toward the output channel.
  ebrp_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  assign out_ch.first_node   = out_word.first_node;
  assign out_ch.node_total   = out_word.node_total;
  assign out_ch.edge_total   = out_word.edge_total;
  assign out_ch.is_end_bound = out_word.is_end_bound;
  assign out_ch.last_result  = out_word.last_result;

endmodule

// ===== bench/tb_edge_balanced_range_partitioner_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_edge_balanced_range_partitioner_top: partitioner stream test
// Sends streams of sorted edge target nodes, with a few out-of-order ids,
// under several quota settings. Each record that comes out is checked field
// by field against a cycle-free model of the cut rules or hand-typed records.
// Both channels stall at random, except in a quiet stretch at the end.
// ----------------------------------------------------------------------------
module tb_edge_balanced_range_partitioner_top;

  import ebrp_pkg::*;

  typedef enum logic [1:0] {ROW_EDGE, ROW_QUOTA} row_kind_t;

  // One line of the directed table: an edge word or a quota write, and for a
  // few edge words the records typed in by hand.
  typedef struct packed {
    row_kind_t         kind;
    logic [31:0]       value;
    logic              is_last;
    logic [1:0]        n_typed;
    result_t           typed0;
    result_t           typed1;
  } stim_row_t;

  localparam logic [THR_BITS-1:0] THR_MAX = {THR_BITS{1'b1}};
  localparam logic [31:0] NODE_TOP = 32'hFFFF_FFFE;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [COUNT_BITS-1:0] cfg_wdata = '0;
  logic sink_ready = 1'b0;
  logic sink_stalls = 1'b0;
  logic calm_tail = 1'b0;
  int   hold_cycles = 0;
  int   mismatches = 0;

  ebrp_in_if  in_ch ();
  ebrp_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  edge_balanced_range_partitioner_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Model state of the partitioner.
  logic [COUNT_BITS-1:0]   quota;
  logic [COUNT_BITS-1:0]   edges_seen;
  logic [COUNT_BITS-1:0]   edges_before;
  logic [NODE_ID_BITS-1:0] open_node;
  logic                    open_valid;
  logic [THR_BITS-1:0]     cut_thr;
  logic [NODE_ID_BITS-1:0] part_first;
  logic [COUNT_BITS-1:0]   part_nodes;
  logic [COUNT_BITS-1:0]   part_edges;

  result_t step_parts[$];
  result_t expected_parts[$];
  stim_row_t stim_rows[$];

  function automatic result_t part_rec(input logic [31:0] first, input logic [31:0] nodes,
                                       input logic [31:0] edges, input logic endb,
                                       input logic lastr);
    result_t r;
    r.first_node   = first;
    r.node_total   = nodes;
    r.edge_total   = edges;
    r.is_end_bound = endb;
    r.last_result  = lastr;
    return r;
  endfunction

  function automatic void clear_partition();
    edges_seen   = '0;
    edges_before = '0;
    open_node    = '0;
    open_valid   = 1'b0;
    cut_thr      = {1'b0, quota};
    part_first   = '0;
    part_nodes   = '0;
    part_edges   = '0;
  endfunction

  // Advance the partition model by one edge; the records it causes land in
  // step_parts, in emission order.
  function automatic void partition_step(input logic [NODE_ID_BITS-1:0] node,
                                         input logic is_last);
    logic [COUNT_BITS-1:0] tail;
    logic [THR_BITS:0]     sum_ab;
    logic [THR_BITS:0]     twice_thr;
    logic [THR_BITS:0]     bumped;
    result_t               r;
    step_parts.delete();
    if (!open_valid) begin
      part_first = node;
      part_nodes = '0;
      part_edges = '0;
    end
    if (!open_valid || open_node != node) begin
      // A new node after the running count reached the threshold closes the part.
      if (open_valid && {1'b0, edges_seen} >= cut_thr) begin
        tail      = edges_seen - edges_before;
        sum_ab    = {2'b00, edges_before} + {2'b00, edges_seen};
        twice_thr = {cut_thr, 1'b0};
        if (twice_thr < sum_ab) begin
          // Midpoint of the previous node lies past the threshold: it moves on.
          step_parts.push_back(part_rec(part_first, part_nodes - 1, part_edges - tail,
                                        1'b0, 1'b0));
          part_first = open_node;
          part_nodes = 1;
          part_edges = tail;
        end else begin
          step_parts.push_back(part_rec(part_first, part_nodes, part_edges, 1'b0, 1'b0));
          part_first = node;
          part_nodes = '0;
          part_edges = '0;
        end
        bumped  = {1'b0, cut_thr} + {2'b00, quota};
        cut_thr = (bumped > {1'b0, THR_MAX}) ? THR_MAX : bumped[THR_BITS-1:0];
      end
      part_nodes   = part_nodes + 1;
      edges_before = edges_seen;
      open_node    = node;
      open_valid   = 1'b1;
    end
    part_edges = part_edges + 1;
    edges_seen = edges_seen + 1;
    // Stream end: open part, then the end bound, then back to a fresh stream.
    if (is_last) begin
      step_parts.push_back(part_rec(part_first, part_nodes, part_edges, 1'b0, 1'b0));
      step_parts.push_back(part_rec(node + 1, '0, '0, 1'b1, 1'b0));
      clear_partition();
    end
    if (step_parts.size() != 0) begin
      r = step_parts.pop_back();
      r.last_result = 1'b1;
      step_parts.push_back(r);
    end
  endfunction

  function automatic stim_row_t edge_row(input logic [31:0] node, input logic is_last);
    return '{kind: ROW_EDGE, value: node, is_last: is_last, n_typed: 2'd0,
             typed0: '0, typed1: '0};
  endfunction

  function automatic stim_row_t quota_row(input logic [31:0] q);
    return '{kind: ROW_QUOTA, value: q, is_last: 1'b0, n_typed: 2'd0,
             typed0: '0, typed1: '0};
  endfunction

  function automatic stim_row_t typed_row(input logic [31:0] node, input result_t t0,
                                          input result_t t1);
    return '{kind: ROW_EDGE, value: node, is_last: 1'b1, n_typed: 2'd2,
             typed0: t0, typed1: t1};
  endfunction

  function automatic logic [31:0] clamp_node(input logic [32:0] v);
    return (v > {1'b0, NODE_TOP}) ? NODE_TOP : v[31:0];
  endfunction

  // Mostly repeats and small steps up; now and then an arbitrary id.
  function automatic logic [31:0] next_node(input logic [31:0] prev);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 9) return prev;
    if (pick < 18) return clamp_node({1'b0, prev} + 33'($urandom_range(1, 3)));
    return clamp_node({1'b0, $urandom});
  endfunction

  function automatic logic [31:0] pick_quota();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      3, 4: return 32'($urandom_range(7, 40));
      default: return 32'($urandom_range(1, 6));
    endcase
  endfunction

  // Quota write once the block has drained; the model follows at the same edge.
  task automatic write_quota(input logic [31:0] q);
    in_ch.valid <= 1'b0;
    while (expected_parts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= q;
    quota = q;
    if (!open_valid && edges_seen == '0) cut_thr = {1'b0, q};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random hold-off on the input side before the next word.
  task automatic pause_input();
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Present one edge word and wait for it to be taken; valid stays high so the
  // caller decides whether the next word follows back to back.
  task automatic send_edge(input logic [31:0] node, input logic is_last,
                           input logic [1:0] n_typed, input result_t t0, input result_t t1);
    in_ch.valid       <= 1'b1;
    in_ch.target_node <= node;
    in_ch.last_edge   <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    partition_step(node, is_last);
    if (n_typed != 0) begin
      expected_parts.push_back(t0);
      expected_parts.push_back(t1);
    end else begin
      foreach (step_parts[i]) expected_parts.push_back(step_parts[i]);
    end
  endtask

  // Result side: random stall bursts.
  always @(posedge clk) begin
    if (calm_tail || !sink_stalls) begin
      sink_ready <= 1'b1;
    end else if (hold_cycles != 0) begin
      sink_ready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_ready  <= 1'b0;
      hold_cycles <= $urandom_range(0, 5);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Every record taken is compared with the oldest one still expected.
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = part_rec(out_ch.first_node, out_ch.node_total, out_ch.edge_total,
                      out_ch.is_end_bound, out_ch.last_result);
      if (expected_parts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected record: first=%0h nodes=%0d edges=%0d end=%0b last=%0b",
                   seen.first_node, seen.node_total, seen.edge_total,
                   seen.is_end_bound, seen.last_result);
      end else begin
        want = expected_parts.pop_front();
        if (seen.first_node !== want.first_node || seen.node_total !== want.node_total ||
            seen.edge_total !== want.edge_total ||
            seen.is_end_bound !== want.is_end_bound ||
            seen.last_result !== want.last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("record mismatch: expected first=%0h nodes=%0d edges=%0d end=%0b last=%0b, got first=%0h nodes=%0d edges=%0d end=%0b last=%0b",
                     want.first_node, want.node_total, want.edge_total,
                     want.is_end_bound, want.last_result,
                     seen.first_node, seen.node_total, seen.edge_total,
                     seen.is_end_bound, seen.last_result);
        end
      end
    end
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("edge_balanced_range_partitioner_top test failed");
    $finish;
  end

  initial begin
    stim_row_t   row;
    logic [31:0] node;
    int          stream_len;
    int          random_edges;

    in_ch.valid       <= 1'b0;
    in_ch.target_node <= '0;
    in_ch.last_edge   <= 1'b0;
    quota = 32'd1;
    clear_partition();

    // After reset the quota is one; a one-edge stream gives its part and the bound.
    stim_rows.push_back(typed_row(32'd0, part_rec(32'd0, 32'd1, 32'd1, 1'b0, 1'b0),
                                  part_rec(32'd1, 32'd0, 32'd0, 1'b1, 1'b1)));
    stim_rows.push_back(typed_row(NODE_TOP, part_rec(NODE_TOP, 32'd1, 32'd1, 1'b0, 1'b0),
                                  part_rec(32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1, 1'b1)));
    stim_rows.push_back(edge_row(32'd5, 1'b0));
    stim_rows.push_back(edge_row(32'd5, 1'b0));
    stim_rows.push_back(edge_row(32'd6, 1'b0));
    stim_rows.push_back(edge_row(32'd7, 1'b0));
    stim_rows.push_back(edge_row(32'd7, 1'b0));
    stim_rows.push_back(edge_row(32'd7, 1'b0));
    stim_rows.push_back(edge_row(32'd8, 1'b1));
    // Zero quota: every new node closes a part.
    stim_rows.push_back(quota_row(32'd0));
    stim_rows.push_back(edge_row(32'd3, 1'b0));
    stim_rows.push_back(edge_row(32'd4, 1'b0));
    stim_rows.push_back(edge_row(32'd4, 1'b0));
    stim_rows.push_back(edge_row(32'd5, 1'b1));
    // Largest quota: no cut can be reached.
    stim_rows.push_back(quota_row(32'hFFFF_FFFF));
    stim_rows.push_back(edge_row(32'd9, 1'b0));
    stim_rows.push_back(edge_row(32'd9, 1'b1));
    // Ids going down still count as new nodes.
    stim_rows.push_back(quota_row(32'd3));
    stim_rows.push_back(edge_row(32'd10, 1'b0));
    stim_rows.push_back(edge_row(32'd10, 1'b0));
    stim_rows.push_back(edge_row(32'd4, 1'b0));
    stim_rows.push_back(edge_row(32'd4, 1'b0));
    stim_rows.push_back(edge_row(32'd2, 1'b1));
    // Quota changed in the middle of a stream keeps the current threshold.
    stim_rows.push_back(edge_row(32'd20, 1'b0));
    stim_rows.push_back(edge_row(32'd20, 1'b0));
    stim_rows.push_back(quota_row(32'd2));
    stim_rows.push_back(edge_row(32'd21, 1'b0));
    stim_rows.push_back(edge_row(32'd21, 1'b0));
    stim_rows.push_back(edge_row(32'd22, 1'b1));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    sink_stalls = 1'b1;

    // Directed table.
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_QUOTA) begin
        write_quota(row.value);
      end else begin
        pause_input();
        send_edge(row.value, row.is_last, row.n_typed, row.typed0, row.typed1);
      end
    end

    // Random streams, mostly sorted, with a quiet stretch at the end.
    random_edges = 0;
    while (random_edges < 90) begin
      sink_stalls = ($urandom_range(0, 3) != 0);
      if (!calm_tail && $urandom_range(0, 9) < 7) write_quota(pick_quota());
      stream_len = $urandom_range(1, 16);
      node = $urandom_range(0, 1) ? 32'($urandom_range(0, 1000)) : clamp_node({1'b0, $urandom});
      for (int k = 0; k < stream_len; k++) begin
        calm_tail = (random_edges >= 72);
        if (k != 0) node = next_node(node);
        if (!calm_tail && k != 0 && k == stream_len / 2 && $urandom_range(0, 9) == 0)
          write_quota(pick_quota());
        pause_input();
        send_edge(node, k == stream_len - 1, 2'd0, '0, '0);
        random_edges++;
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_parts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_parts.size() == 0) begin
      $display("edge_balanced_range_partitioner_top test passed");
    end else begin
      $display("edge_balanced_range_partitioner_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ebrp_pkg.sv
hw/rtl/ebrp_ifs.sv
hw/rtl/ebrp_core.sv
hw/rtl/ebrp_result_queue.sv
hw/rtl/edge_balanced_range_partitioner_top.sv
bench/tb_edge_balanced_range_partitioner_top.sv
